// File: design/lbps_pkg.sv
// Shared types, constants and pattern ROM for the LED/beeper pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none
package lbps_pkg;

  localparam int STEP_W        = 4;
  localparam int PAT_W         = 10;
  localparam int ROW_W         = 4;
  localparam int EVENT_COUNT   = 16;
  localparam int PATTERN_STEPS = 10;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [STEP_W-1:0] PATTERN_STEPS_C = STEP_W'(PATTERN_STEPS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LED1_PRESENT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LED2_PRESENT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BEEPER_PRESENT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BEEPER_SPEAKER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PRESENT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEAKER_PULSE  = 3'd5;

  // Item function codes
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_TRIGGER = 1'b1;

  // Pattern rows
  localparam logic [ROW_W-1:0] ROW_OFF            = 4'd0;
  localparam logic [ROW_W-1:0] ROW_DISARMED       = 4'd1;
  localparam logic [ROW_W-1:0] ROW_DISARMED_FIX   = 4'd2;
  localparam logic [ROW_W-1:0] ROW_ARMED          = 4'd3;
  localparam logic [ROW_W-1:0] ROW_FLYING         = 4'd4;
  localparam logic [ROW_W-1:0] ROW_FLYING_HF      = 4'd5;
  localparam logic [ROW_W-1:0] ROW_ALT_HOLD       = 4'd6;
  localparam logic [ROW_W-1:0] ROW_POS_HOLD       = 4'd7;
  localparam logic [ROW_W-1:0] ROW_MISSION        = 4'd8;
  localparam logic [ROW_W-1:0] ROW_DVH            = 4'd9;
  localparam logic [ROW_W-1:0] ROW_LOW_BATT1      = 4'd10;
  localparam logic [ROW_W-1:0] ROW_LOW_BATT2      = 4'd11;
  localparam logic [ROW_W-1:0] ROW_RADIO_LOSS2    = 4'd12;

  // Navigation modes
  localparam logic [2:0] NAV_ALT_HOLD = 3'd1;
  localparam logic [2:0] NAV_POS_HOLD = 3'd2;
  localparam logic [2:0] NAV_MISSION  = 3'd3;
  localparam logic [2:0] NAV_DVH      = 3'd4;

  localparam logic [1:0] GPS_FIX_3D = 2'd3;

  typedef struct packed {
    logic       func;
    logic [4:0] event_code;
    logic [6:0] flight_flags;
    logic [2:0] nav_mode;
    logic [1:0] gps_fix_type;
    logic       headfree_on;
  } in_item_t;

  typedef struct packed {
    logic        led1_level;
    logic        led2_level;
    logic [15:0] beeper_value;
    logic [10:0] pwm_width;
  } out_item_t;

  typedef struct packed {
    logic        led1_present;
    logic        led2_present;
    logic        beeper_present;
    logic        beeper_is_speaker;
    logic        pwm_present;
    logic [15:0] speaker_pulse_length;
  } cfg_t;

  typedef struct packed {
    logic [PAT_W-1:0] l1;
    logic [PAT_W-1:0] l2;
    logic [PAT_W-1:0] bp;
    logic [10:0]      pw;
  } row_t;

  // One-time event phase
  typedef enum logic [2:0] {
    PH_START    = 3'b001,
    PH_FINISHED = 3'b010,
    PH_PLAYING  = 3'b100
  } phase_t;

  function automatic row_t rom_row(input logic [ROW_W-1:0] idx);
    row_t r;
    case (idx)
      4'd0:    r = '{10'h000, 10'h000, 10'h000, 11'd1000};
      4'd1:    r = '{10'h333, 10'h000, 10'h000, 11'd1025};
      4'd2:    r = '{10'h01F, 10'h000, 10'h000, 11'd1075};
      4'd3:    r = '{10'h3FF, 10'h000, 10'h000, 11'd1125};
      4'd4:    r = '{10'h3FF, 10'h000, 10'h000, 11'd1175};
      4'd5:    r = '{10'h0FF, 10'h000, 10'h000, 11'd1575};
      4'd6:    r = '{10'h3FF, 10'h021, 10'h000, 11'd1225};
      4'd7:    r = '{10'h3FF, 10'h3FF, 10'h000, 11'd1275};
      4'd8:    r = '{10'h3FF, 10'h020, 10'h000, 11'd1325};
      4'd9:    r = '{10'h3FF, 10'h2AA, 10'h000, 11'd1375};
      4'd10:   r = '{10'h003, 10'h300, 10'h009, 11'd1425};
      4'd11:   r = '{10'h132, 10'h049, 10'h0C3, 11'd1475};
      4'd12:   r = '{10'h132, 10'h049, 10'h16B, 11'd1525};
      4'd13:   r = '{10'h3FF, 10'h01F, 10'h004, 11'd1025};
      4'd14:   r = '{10'h3FF, 10'h3E0, 10'h014, 11'd1125};
      default: r = '{10'h333, 10'h0CC, 10'h3FF, 11'd1525};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/led_beeper_pattern_sequencer.sv
// Top level of the LED/beeper status pattern sequencer.
//
// Usage: in_data carries one item per handshake on in_valid/in_ready. A tick
// item (func = 0) drives the outputs from the row picked by the flight flags,
// or from a pending one-time event, at the current step and advances the step.
// A trigger item (func = 1) arms a one-time event; a trigger that replaces a
// pending event gives one all-off result. Items that change nothing visible
// (disabled ticks, start ticks, ignored triggers) give no result.
// Results leave on out_data with out_valid/out_ready.
// cfg_valid/cfg_index/cfg_data write the configuration registers; cfg_ready is
// always high. Write them only while the block is idle.
// An accepted item waits in the input register; its result is formed from it
// combinationally and enters the output register when the item advances.
// Throughput: one item per cycle while the receiver takes results, set by the
// input register -> row ROM -> result register path.
// Reset clears configuration, step, pending event and all valid flags.
// When the receiver stalls, the result holds and the input register holds one
// more item; in_ready drops only once both are full and a result is waiting.
`timescale 1ns / 1ps
`default_nettype none
module led_beeper_pattern_sequencer (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire lbps_pkg::in_item_t                   in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output lbps_pkg::out_item_t                       out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [lbps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lbps_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lbps_pkg::*;

  // Configuration
  cfg_t cfg;

  // Input register
  logic     item_valid;
  in_item_t item;

  // Sequencer state
  logic [STEP_W-1:0] step, step_next;
  logic [ROW_W-1:0]  oneshot_event, oneshot_event_next;
  phase_t            phase, phase_next;

  logic [ROW_W-1:0]  pick_row;
  logic [ROW_W-1:0]  emit_row;
  logic [STEP_W-1:0] step_inc;
  logic              has_result;
  logic              advance;
  logic              enabled;
  out_item_t         result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LED1_PRESENT:   cfg.led1_present         <= cfg_data[0];
        CFG_LED2_PRESENT:   cfg.led2_present         <= cfg_data[0];
        CFG_BEEPER_PRESENT: cfg.beeper_present       <= cfg_data[0];
        CFG_BEEPER_SPEAKER: cfg.beeper_is_speaker    <= cfg_data[0];
        CFG_PWM_PRESENT:    cfg.pwm_present          <= cfg_data[0];
        CFG_SPEAKER_PULSE:  cfg.speaker_pulse_length <= cfg_data;
        default: ;
      endcase
    end
  end

  lbps_row_sel u_row_sel (
    .flight_flags (item.flight_flags),
    .nav_mode     (item.nav_mode),
    .gps_fix_type (item.gps_fix_type),
    .headfree_on  (item.headfree_on),
    .row          (pick_row)
  );

  lbps_emit u_emit (
    .row    (emit_row),
    .step   (step),
    .cfg    (cfg),
    .result (result)
  );

  assign enabled  = cfg.led1_present | cfg.led2_present | cfg.beeper_present | cfg.pwm_present;
  assign step_inc = step + STEP_W'(1);

  // Work out the effect of the held item on state and whether it yields a result
  always_comb begin
    step_next          = step;
    oneshot_event_next = oneshot_event;
    phase_next         = phase;
    emit_row           = ROW_OFF;
    has_result         = 1'b0;
    if (item.func == FUNC_TRIGGER) begin
      // Codes past the table are dropped
      if (!item.event_code[4]) begin
        has_result         = (oneshot_event != ROW_OFF);
        phase_next         = PH_START;
        oneshot_event_next = item.event_code[ROW_W-1:0];
      end
    end else if (enabled) begin
      if (oneshot_event != ROW_OFF) begin
        case (phase)
          PH_START: begin
            phase_next = PH_PLAYING;
            step_next  = '0;
          end
          PH_PLAYING: begin
            emit_row   = oneshot_event;
            has_result = 1'b1;
            step_next  = step_inc;
            if (step_inc >= PATTERN_STEPS_C) begin
              phase_next = PH_FINISHED;
            end
          end
          default: begin
            // Finished: force everything off once and resume
            phase_next         = PH_START;
            oneshot_event_next = ROW_OFF;
            step_next          = '0;
            has_result         = 1'b1;
          end
        endcase
      end else begin
        emit_row   = pick_row;
        has_result = 1'b1;
        step_next  = (step_inc >= PATTERN_STEPS_C) ? '0 : step_inc;
      end
    end
  end

  // Hold the item until the result register can take its result
  assign advance  = item_valid & (~has_result | ~out_valid | out_ready);
  assign in_ready = ~item_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= '0;
      oneshot_event <= ROW_OFF;
      phase         <= PH_START;
    end else if (advance) begin
      step          <= step_next;
      oneshot_event <= oneshot_event_next;
      phase         <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire

// File: design/lbps_row_sel.sv
// Ongoing-signalling row selection from the flight status of a tick item.
`timescale 1ns / 1ps
`default_nettype none
module lbps_row_sel (
  input  wire logic [6:0]                flight_flags,
  input  wire logic [2:0]                nav_mode,
  input  wire logic [1:0]                gps_fix_type,
  input  wire logic                      headfree_on,
  output logic      [lbps_pkg::ROW_W-1:0] row
);
  import lbps_pkg::*;

  logic [ROW_W-1:0] fly_row;

  always_comb begin
    case (nav_mode)
      NAV_ALT_HOLD: fly_row = ROW_ALT_HOLD;
      NAV_POS_HOLD: fly_row = ROW_POS_HOLD;
      NAV_MISSION:  fly_row = ROW_MISSION;
      NAV_DVH:      fly_row = ROW_DVH;
      default:      fly_row = headfree_on ? ROW_FLYING_HF : ROW_FLYING;
    endcase
  end

  // Exact flag combinations only; anything else is the all-off row
  always_comb begin
    case (flight_flags)
      7'h01:   row = (gps_fix_type == GPS_FIX_3D) ? ROW_DISARMED_FIX : ROW_DISARMED;
      7'h02:   row = ROW_ARMED;
      7'h04,
      7'h06:   row = fly_row;
      7'h0E:   row = ROW_LOW_BATT2;
      7'h1E:   row = ROW_RADIO_LOSS2;
      7'h21,
      7'h22,
      7'h26:   row = ROW_LOW_BATT1;
      7'h61,
      7'h62,
      7'h66:   row = ROW_LOW_BATT2;
      default: row = ROW_OFF;
    endcase
  end

endmodule
`default_nettype wire

// File: design/lbps_emit.sv
// Output formatting of one pattern row at one step.
`timescale 1ns / 1ps
`default_nettype none
module lbps_emit (
  input  wire logic [lbps_pkg::ROW_W-1:0]  row,
  input  wire logic [lbps_pkg::STEP_W-1:0] step,
  input  wire lbps_pkg::cfg_t              cfg,
  output lbps_pkg::out_item_t              result
);
  import lbps_pkg::*;

  row_t r;
  logic in_pat;
  logic b1, b2, bb;

  assign r      = rom_row(row);
  assign in_pat = (step < STEP_W'(PAT_W));
  assign b1     = in_pat & r.l1[step];
  assign b2     = in_pat & r.l2[step];
  assign bb     = in_pat & r.bp[step];

  always_comb begin
    result.led1_level = cfg.led1_present & b1;
    result.led2_level = cfg.led2_present & b2;
    if (!cfg.beeper_present || !bb) begin
      result.beeper_value = '0;
    end else if (cfg.beeper_is_speaker) begin
      result.beeper_value = cfg.speaker_pulse_length;
    end else begin
      result.beeper_value = 16'd1;
    end
    result.pwm_width = cfg.pwm_present ? r.pw : 11'd0;
  end

endmodule
`default_nettype wire

// File: tb/tb_led_beeper_pattern_sequencer.sv
// Self-checking testbench for the LED/beeper status pattern sequencer.
`timescale 1ns / 1ps
module tb_led_beeper_pattern_sequencer;
  import lbps_pkg::*;

  // Flight flag bits and the run length of the whole regression
  localparam logic [6:0] FL_DISARMED = 7'h01;
  localparam logic [6:0] FL_ARMED    = 7'h02;
  localparam logic [6:0] FL_FLYING   = 7'h04;
  localparam logic [6:0] FL_RADIO1   = 7'h08;
  localparam logic [6:0] FL_RADIO2   = 7'h10;
  localparam logic [6:0] FL_BATT1    = 7'h20;
  localparam logic [6:0] FL_BATT2    = 7'h40;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int RANDOM_PHASES  = 11;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int SETTLE_CYCLES  = 6;

  typedef enum logic {DIR_ITEM, DIR_WRITE} dir_kind_t;

  // One row of the directed walk: either an item or a register write. Typed
  // rows carry the result that the row must give; the rest use the predictor.
  typedef struct packed {
    dir_kind_t   kind;
    logic        typed;
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    in_item_t    item;
    out_item_t   res;
  } dir_row_t;

  localparam out_item_t ALL_OFF  = '0;
  localparam out_item_t ROW0_PWM = '{1'b0, 1'b0, 16'd0, 11'd1000};
  localparam in_item_t  NO_ITEM  = '0;
  localparam in_item_t  PLAIN_TICK = '{FUNC_TICK, 5'd0, FL_ARMED, 3'd0, 2'd0, 1'b0};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  led_beeper_pattern_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the pattern ROM, the registers and the sequencer state
  row_t pattern_rom [0:15] = '{
    '{10'h000, 10'h000, 10'h000, 11'd1000},
    '{10'h333, 10'h000, 10'h000, 11'd1025},
    '{10'h01F, 10'h000, 10'h000, 11'd1075},
    '{10'h3FF, 10'h000, 10'h000, 11'd1125},
    '{10'h3FF, 10'h000, 10'h000, 11'd1175},
    '{10'h0FF, 10'h000, 10'h000, 11'd1575},
    '{10'h3FF, 10'h021, 10'h000, 11'd1225},
    '{10'h3FF, 10'h3FF, 10'h000, 11'd1275},
    '{10'h3FF, 10'h020, 10'h000, 11'd1325},
    '{10'h3FF, 10'h2AA, 10'h000, 11'd1375},
    '{10'h003, 10'h300, 10'h009, 11'd1425},
    '{10'h132, 10'h049, 10'h0C3, 11'd1475},
    '{10'h132, 10'h049, 10'h16B, 11'd1525},
    '{10'h3FF, 10'h01F, 10'h004, 11'd1025},
    '{10'h3FF, 10'h3E0, 10'h014, 11'd1125},
    '{10'h333, 10'h0CC, 10'h3FF, 11'd1525}
  };

  // Flag combinations that select a row of their own
  logic [6:0] listed_flags [0:11] = '{
    FL_DISARMED, FL_ARMED, FL_FLYING, FL_ARMED | FL_FLYING,
    FL_ARMED | FL_FLYING | FL_RADIO1, FL_ARMED | FL_FLYING | FL_RADIO1 | FL_RADIO2,
    FL_ARMED | FL_BATT1, FL_ARMED | FL_FLYING | FL_BATT1, FL_DISARMED | FL_BATT1,
    FL_ARMED | FL_BATT1 | FL_BATT2, FL_ARMED | FL_FLYING | FL_BATT1 | FL_BATT2,
    FL_DISARMED | FL_BATT1 | FL_BATT2
  };

  cfg_t        shadow_cfg = '0;
  logic [3:0]  step_pos = '0;
  logic [3:0]  oneshot_row = ROW_OFF;
  phase_t      oneshot_phase = PH_START;

  out_item_t   awaited_status [$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          idle_en = 1'b1;
  out_item_t   want_res;

  // Directed walk: disabled block first, then the edges of the row selection
  // and one full pass of a one-time event with the beeper held on throughout.
  dir_row_t directed_rows [0:30] = '{
    // disabled tick: nothing happens
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, '{FUNC_TICK, 5'd0, FL_DISARMED, 3'd0, 2'd0, 1'b0}, ALL_OFF},
    // code past the last row: ignored
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, '{FUNC_TRIGGER, 5'd31, 7'h7F, 3'd7, 2'd3, 1'b1}, ALL_OFF},
    // arm a one-time event, then replace it and then cancel it
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, '{FUNC_TRIGGER, 5'd5, 7'h00, 3'd0, 2'd0, 1'b0}, ALL_OFF},
    '{DIR_ITEM, 1'b1, 3'd0, 16'd0, '{FUNC_TRIGGER, 5'd9, 7'h00, 3'd0, 2'd0, 1'b0}, ALL_OFF},
    '{DIR_ITEM, 1'b1, 3'd0, 16'd0, '{FUNC_TRIGGER, 5'd0, 7'h00, 3'd0, 2'd0, 1'b0}, ALL_OFF},
    // enable every output, speaker at full compare
    '{DIR_WRITE, 1'b0, CFG_LED1_PRESENT,   16'd1,     NO_ITEM, ALL_OFF},
    '{DIR_WRITE, 1'b0, CFG_LED2_PRESENT,   16'd1,     NO_ITEM, ALL_OFF},
    '{DIR_WRITE, 1'b0, CFG_BEEPER_PRESENT, 16'd1,     NO_ITEM, ALL_OFF},
    '{DIR_WRITE, 1'b0, CFG_BEEPER_SPEAKER, 16'd1,     NO_ITEM, ALL_OFF},
    '{DIR_WRITE, 1'b0, CFG_PWM_PRESENT,    16'd1,     NO_ITEM, ALL_OFF},
    '{DIR_WRITE, 1'b0, CFG_SPEAKER_PULSE,  16'hFFFF,  NO_ITEM, ALL_OFF},
    // no flags and all flags: both unlisted, so the all-off row
    '{DIR_ITEM, 1'b1, 3'd0, 16'd0, '{FUNC_TICK, 5'd0, 7'h00, 3'd0, 2'd0, 1'b0}, ROW0_PWM},
    '{DIR_ITEM, 1'b1, 3'd0, 16'd0, '{FUNC_TICK, 5'd31, 7'h7F, 3'd7, 2'd3, 1'b1}, ROW0_PWM},
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, '{FUNC_TICK, 5'd0, FL_DISARMED, 3'd0, GPS_FIX_3D, 1'b0},
      ALL_OFF},
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, '{FUNC_TICK, 5'd0, FL_ARMED, 3'd0, 2'd0, 1'b0}, ALL_OFF},
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0,
      '{FUNC_TICK, 5'd0, FL_ARMED | FL_FLYING, NAV_DVH, 2'd0, 1'b0}, ALL_OFF},
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, '{FUNC_TICK, 5'd0, FL_FLYING, 3'd0, 2'd0, 1'b1}, ALL_OFF},
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0,
      '{FUNC_TICK, 5'd0, FL_DISARMED | FL_BATT1 | FL_BATT2, 3'd0, 2'd0, 1'b0}, ALL_OFF},
    // one-time event on the last row: start tick, ten playing ticks, off tick
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, '{FUNC_TRIGGER, 5'd15, 7'h00, 3'd0, 2'd0, 1'b0}, ALL_OFF},
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, PLAIN_TICK, ALL_OFF},
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, PLAIN_TICK, ALL_OFF},
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, PLAIN_TICK, ALL_OFF},
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, PLAIN_TICK, ALL_OFF},
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, PLAIN_TICK, ALL_OFF},
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, PLAIN_TICK, ALL_OFF},
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, PLAIN_TICK, ALL_OFF},
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, PLAIN_TICK, ALL_OFF},
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, PLAIN_TICK, ALL_OFF},
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, PLAIN_TICK, ALL_OFF},
    '{DIR_ITEM, 1'b0, 3'd0, 16'd0, PLAIN_TICK, ALL_OFF},
    '{DIR_ITEM, 1'b1, 3'd0, 16'd0, PLAIN_TICK, ROW0_PWM}
  };

  // Pattern bit at the current step; steps past the pattern read as zero
  function automatic logic pat_bit(input logic [PAT_W-1:0] pat);
    return (step_pos < PATTERN_STEPS_C) ? pat[step_pos] : 1'b0;
  endfunction

  // Outputs of one ROM row at the current step under the current registers
  function automatic out_item_t drive_row(input logic [3:0] row_idx);
    row_t      r;
    logic      beep;
    out_item_t o;
    r = pattern_rom[row_idx];
    beep = pat_bit(r.bp);
    o.led1_level   = shadow_cfg.led1_present ? pat_bit(r.l1) : 1'b0;
    o.led2_level   = shadow_cfg.led2_present ? pat_bit(r.l2) : 1'b0;
    o.beeper_value = !shadow_cfg.beeper_present ? 16'd0 :
                     shadow_cfg.beeper_is_speaker ?
                       (beep ? shadow_cfg.speaker_pulse_length : 16'd0) : {15'd0, beep};
    o.pwm_width    = shadow_cfg.pwm_present ? r.pw : 11'd0;
    return o;
  endfunction

  // Ongoing row from the exact flag combination
  function automatic logic [3:0] pick_row(input in_item_t it);
    case (it.flight_flags)
      FL_DISARMED: return (it.gps_fix_type == GPS_FIX_3D) ? ROW_DISARMED_FIX : ROW_DISARMED;
      FL_ARMED:    return ROW_ARMED;
      FL_FLYING, FL_ARMED | FL_FLYING: begin
        case (it.nav_mode)
          NAV_ALT_HOLD: return ROW_ALT_HOLD;
          NAV_POS_HOLD: return ROW_POS_HOLD;
          NAV_MISSION:  return ROW_MISSION;
          NAV_DVH:      return ROW_DVH;
          default:      return it.headfree_on ? ROW_FLYING_HF : ROW_FLYING;
        endcase
      end
      FL_ARMED | FL_FLYING | FL_RADIO1:             return ROW_LOW_BATT2;
      FL_ARMED | FL_FLYING | FL_RADIO1 | FL_RADIO2: return ROW_RADIO_LOSS2;
      FL_ARMED | FL_BATT1, FL_ARMED | FL_FLYING | FL_BATT1,
      FL_DISARMED | FL_BATT1:                       return ROW_LOW_BATT1;
      FL_ARMED | FL_BATT1 | FL_BATT2, FL_ARMED | FL_FLYING | FL_BATT1 | FL_BATT2,
      FL_DISARMED | FL_BATT1 | FL_BATT2:            return ROW_LOW_BATT2;
      default:                                      return ROW_OFF;
    endcase
  endfunction

  // Advance the shadow state by one item; returns 1 when the item gives a result
  function automatic bit predict_status(input in_item_t it, output out_item_t res);
    bit got;
    res = '0;
    got = 1'b0;
    if (it.func == FUNC_TRIGGER) begin
      if (it.event_code >= EVENT_COUNT) return 1'b0;
      // replacing a pending event blanks everything once
      if (oneshot_row != ROW_OFF) begin
        res = drive_row(ROW_OFF);
        got = 1'b1;
      end
      oneshot_phase = PH_START;
      oneshot_row = it.event_code[3:0];
      return got;
    end
    if (!(shadow_cfg.led1_present | shadow_cfg.led2_present |
          shadow_cfg.beeper_present | shadow_cfg.pwm_present)) return 1'b0;
    if (oneshot_row != ROW_OFF) begin
      case (oneshot_phase)
        PH_START: begin
          oneshot_phase = PH_PLAYING;
          step_pos = '0;
          return 1'b0;
        end
        PH_PLAYING: begin
          res = drive_row(oneshot_row);
          step_pos = step_pos + 4'd1;
          if (step_pos >= PATTERN_STEPS_C) oneshot_phase = PH_FINISHED;
          return 1'b1;
        end
        default: begin
          // pass done: clear the event and force everything off
          oneshot_phase = PH_START;
          oneshot_row = ROW_OFF;
          step_pos = '0;
          res = drive_row(ROW_OFF);
          return 1'b1;
        end
      endcase
    end
    res = drive_row(pick_row(it));
    step_pos = step_pos + 4'd1;
    if (step_pos >= PATTERN_STEPS_C) step_pos = '0;
    return 1'b1;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  // Offer one item and hold it until taken; predict at the accepting edge.
  // Leave valid high on return so that a following item needs no re-raise.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t res;
    bit        got;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    got = predict_status(it, res);
    if (typed) awaited_status.push_back(typed_res);
    else if (got) awaited_status.push_back(res);
    @(negedge clk);
  endtask

  // Occasional random sender gap while idling is on
  task automatic sender_gap();
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  // Hold the sender off until every awaited result has arrived, then let the
  // pipeline settle in case the last item gave no result.
  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_status.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write; valid is left high for back-to-back writes
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LED1_PRESENT:   shadow_cfg.led1_present = val[0];
      CFG_LED2_PRESENT:   shadow_cfg.led2_present = val[0];
      CFG_BEEPER_PRESENT: shadow_cfg.beeper_present = val[0];
      CFG_BEEPER_SPEAKER: shadow_cfg.beeper_is_speaker = val[0];
      CFG_PWM_PRESENT:    shadow_cfg.pwm_present = val[0];
      CFG_SPEAKER_PULSE:  shadow_cfg.speaker_pulse_length = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(input cfg_t s);
    drain();
    write_reg(CFG_LED1_PRESENT,   {15'd0, s.led1_present});
    write_reg(CFG_LED2_PRESENT,   {15'd0, s.led2_present});
    write_reg(CFG_BEEPER_PRESENT, {15'd0, s.beeper_present});
    write_reg(CFG_BEEPER_SPEAKER, {15'd0, s.beeper_is_speaker});
    write_reg(CFG_PWM_PRESENT,    {15'd0, s.pwm_present});
    write_reg(CFG_SPEAKER_PULSE,  s.speaker_pulse_length);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stall at random while idling is on
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare every taken result with the oldest awaited one, field by field
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_status.size() == 0) begin
        flag_error($sformatf("unexpected result l1=%0d l2=%0d beep=%0d pwm=%0d",
                   out_data.led1_level, out_data.led2_level,
                   out_data.beeper_value, out_data.pwm_width));
      end else begin
        want_res = awaited_status.pop_front();
        if (out_data.led1_level !== want_res.led1_level ||
            out_data.led2_level !== want_res.led2_level ||
            out_data.beeper_value !== want_res.beeper_value ||
            out_data.pwm_width !== want_res.pwm_width) begin
          flag_error($sformatf(
            "want l1=%0d l2=%0d beep=%0d pwm=%0d, got l1=%0d l2=%0d beep=%0d pwm=%0d",
            want_res.led1_level, want_res.led2_level, want_res.beeper_value,
            want_res.pwm_width, out_data.led1_level, out_data.led2_level,
            out_data.beeper_value, out_data.pwm_width));
        end
      end
    end
  end

  // Watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    bit       was_write;
    cfg_t     s;
    in_item_t it;
    int       sel;
    was_write = 1'b0;

    // Hold reset, then release it on a falling edge
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table; writes wait for the block to go idle
    for (int i = 0; i < 31; i++) begin
      if (directed_rows[i].kind == DIR_WRITE) begin
        if (!was_write) drain();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
        was_write = 1'b1;
      end else begin
        cfg_valid <= 1'b0;
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);
        sender_gap();
        was_write = 1'b0;
      end
    end

    // Random phases, each under its own register setting. The first few pin
    // the extremes: full speaker, buzzer with zero compare, everything absent.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: s = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF};
        1: s = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 16'h0000};
        2: s = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'($urandom)};
        3: s = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000};
        default: s = '{1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                       1'($urandom), 16'($urandom)};
      endcase
      // no idling on one mid phase and on the closing phase
      idle_en = (ph != 4) && (ph != RANDOM_PHASES - 1);
      apply_setting(s);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it.event_code   = 5'($urandom);
        it.flight_flags = 7'($urandom);
        it.nav_mode     = 3'($urandom);
        it.gps_fix_type = 2'($urandom);
        it.headfree_on  = 1'($urandom);
        if ($urandom_range(0, 99) < 6) begin
          // trigger: mostly a real row, sometimes a cancel or an ignored code
          it.func = FUNC_TRIGGER;
          sel = $urandom_range(0, 99);
          if (sel < 75) it.event_code = 5'($urandom_range(1, 15));
          else if (sel < 87) it.event_code = 5'd0;
          else it.event_code = 5'($urandom_range(16, 31));
        end else begin
          it.func = FUNC_TICK;
          if ($urandom_range(0, 9) < 7) it.flight_flags = listed_flags[$urandom_range(0, 11)];
        end
        send_item(it, 1'b0, ALL_OFF);
        sender_gap();
      end
    end

    // Wait for the tail, then give late strays a chance to show up
    in_valid <= 1'b0;
    while (awaited_status.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (error_count == 0 && awaited_status.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
